[design/dmp_pkg.sv]
// Shared types, constants and helper functions for the drifting mote pool.
package dmp_pkg;

	localparam int NUM_MOTES_DEF = 24;
	localparam int ANGLE_BITS_DEF = 10;

	localparam logic [11:0] WIDTH_RST = 12'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;
	localparam logic [31:0] SEED_DEF = 32'h000A_11CE;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd2;

	// spawn draw steps, in draw order
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_X = 3'd0;
	localparam logic [OP_W-1:0] OP_Y = 3'd1;
	localparam logic [OP_W-1:0] OP_ANG = 3'd2;
	localparam logic [OP_W-1:0] OP_SPD = 3'd3;
	localparam logic [OP_W-1:0] OP_TOT = 3'd4;
	localparam logic [OP_W-1:0] OP_LIFE = 3'd5;
	localparam logic [OP_W-1:0] OP_HW = 3'd6;
	localparam logic [OP_W-1:0] OP_SHD = 3'd7;

	localparam int DIV_STEPS = 12;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [21:0] pos_x;
		logic signed [21:0] pos_y;
		logic signed [14:0] vel_x;
		logic signed [14:0] vel_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [19:0] life_left;
		logic [18:0] life_total;
		logic [9:0] hwid;
		logic [11:0] shade;
	} mote_t;

	typedef struct packed {
		logic capture;
		logic draw;
		logic use_en;
		logic [OP_W-1:0] op;
		logic vel;
		logic mem_rd;
		logic mem_wr;
		logic wr_spawn;
		logic up_move;
		logic em_prep;
		logic em_mul;
		logic em_out;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic div_done;
	} sts_t;

	function automatic logic [31:0] xorshift(input logic [31:0] w);
		logic [31:0] v;
		v = w ^ (w << 13);
		v = v ^ (v >> 17);
		v = v ^ (v << 5);
		return v;
	endfunction

	// round to nearest, ties away from zero
	function automatic logic signed [47:0] shr_round(input logic signed [47:0] v,
		input int unsigned sh);
		logic [47:0] m;
		m = v[47] ? 48'(-v) : 48'(v);
		m = (m + (48'd1 << (sh - 1))) >> sh;
		return v[47] ? -$signed(m) : $signed(m);
	endfunction

	// {sin, cos} in Q14 for folded angle index jj; constant use only
	function automatic logic [31:0] sincos_q14(input int unsigned jj, input int unsigned ab);
		longint unsigned a, a2, t, s, c;
		a = (longint'(jj) * HALF_PI_Q30) >> (ab - 2);
		a2 = (a * a) >> 30;
		t = ONE_Q30 - a2 / 72;
		t = ONE_Q30 - ((a2 * t) >> 30) / 42;
		t = ONE_Q30 - ((a2 * t) >> 30) / 20;
		t = ONE_Q30 - ((a2 * t) >> 30) / 6;
		s = (((a * t) >> 30) + (64'd1 << 15)) >> 16;
		t = ONE_Q30 - a2 / 90;
		t = ONE_Q30 - ((a2 * t) >> 30) / 56;
		t = ONE_Q30 - ((a2 * t) >> 30) / 30;
		t = ONE_Q30 - ((a2 * t) >> 30) / 12;
		t = ONE_Q30 - ((a2 * t) >> 30) / 2;
		c = (t + (64'd1 << 15)) >> 16;
		return {s[15:0], c[15:0]};
	endfunction

endpackage

[design/drifting_mote_pool.sv]
// Top level of the drifting mote pool: controller plus datapath.
// A tick word is taken when start is high and busy is low; the block then emits
// NUM_MOTES stroke words, one per result_valid pulse, which cannot be stalled:
// the receiver must take each word in the cycle it is shown. Each tick runs a
// motion and cull pass over all motes, respawns the culled ones from fresh
// random draws, then runs a stroke pass that waits on the bit-serial fade
// divider for each mote. The first tick after reset or a seed write also runs
// an initial fill of the whole pool.
module drifting_mote_pool #(
	parameter int NUM_MOTES = dmp_pkg::NUM_MOTES_DEF,
	parameter int ANGLE_TABLE_BITS = dmp_pkg::ANGLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic start,
	output logic busy,
	input  logic [15:0] tick_dt,
	output logic result_valid,
	output logic signed [21:0] start_x,
	output logic signed [21:0] start_y,
	output logic signed [21:0] end_x,
	output logic signed [21:0] end_y,
	output logic [9:0] stroke_half_width,
	output logic [11:0] gray_level,
	output logic [11:0] blue_level,
	output logic last_stroke
);
	localparam int AW = (NUM_MOTES > 1) ? $clog2(NUM_MOTES) : 1;

	dmp_pkg::cmd_t cmd;
	dmp_pkg::sts_t sts;
	logic [AW-1:0] rd_addr, wr_addr;

	dmp_ctrl #(.NUM_MOTES(NUM_MOTES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.start(start),
		.busy(busy),
		.sts(sts),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr)
	);

	dmp_datapath #(.NUM_MOTES(NUM_MOTES), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_dt(tick_dt),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.sts(sts),
		.result_valid(result_valid),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.stroke_half_width(stroke_half_width),
		.gray_level(gray_level),
		.blue_level(blue_level),
		.last_stroke(last_stroke)
	);

endmodule

[design/dmp_datapath.sv]
// Datapath: mote store, random source, spawn, motion, fade divider, stroke output.
module dmp_datapath #(
	parameter int NUM_MOTES = dmp_pkg::NUM_MOTES_DEF,
	parameter int ANGLE_TABLE_BITS = dmp_pkg::ANGLE_BITS_DEF,
	localparam int AW = (NUM_MOTES > 1) ? $clog2(NUM_MOTES) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [15:0] tick_dt,
	input  dmp_pkg::cmd_t cmd,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	output dmp_pkg::sts_t sts,
	output logic result_valid,
	output logic signed [21:0] start_x,
	output logic signed [21:0] start_y,
	output logic signed [21:0] end_x,
	output logic signed [21:0] end_y,
	output logic [9:0] stroke_half_width,
	output logic [11:0] gray_level,
	output logic [11:0] blue_level,
	output logic last_stroke
);
	localparam int AB = ANGLE_TABLE_BITS;
	localparam int HALFQ = 1 << (AB - 3);
	localparam logic [AB-2:0] QUARTER = (AB-1)'(1 << (AB - 2));

	logic [11:0] width_q, height_q;
	logic [31:0] rng_q, rng_nxt;
	logic [15:0] dt_q;
	logic [23:0] r_q;
	logic [12:0] speed_q;
	dmp_pkg::mote_t sp_q, upd_q, rd_q, wdata;
	dmp_pkg::mote_t mem [NUM_MOTES];
	logic keep_q;

	logic [31:0] sc_tab [HALFQ+1];
	for (genvar g = 0; g <= HALFQ; g++) begin : g_sc
		assign sc_tab[g] = dmp_pkg::sincos_q14(g, AB);
	end

	assign rng_nxt = dmp_pkg::xorshift(rng_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= dmp_pkg::WIDTH_RST;
			height_q <= dmp_pkg::HEIGHT_RST;
			rng_q <= dmp_pkg::SEED_DEF;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					dmp_pkg::CFG_WIDTH: width_q <= cfg_data[11:0];
					dmp_pkg::CFG_HEIGHT: height_q <= cfg_data[11:0];
					dmp_pkg::CFG_SEED: rng_q <= (cfg_data == 32'd0) ? dmp_pkg::SEED_DEF : cfg_data;
					default: ;
				endcase
			end else if (cmd.draw) begin
				rng_q <= rng_nxt;
			end
		end
	end

	// spawn arithmetic
	logic [35:0] prod_w, prod_h;
	logic [27:0] prod_s;
	logic [42:0] prod_l;
	logic [34:0] prod_k;
	logic [AB-1:0] ang_idx;
	logic [AB-3:0] ang_j;
	logic [AB-2:0] ang_jj;
	logic ang_swap;
	logic [31:0] sc;
	logic signed [15:0] s_v, c_v, sa, ca, dx, dy;
	logic [18:0] tot_v;

	always_comb begin
		prod_w = r_q * width_q;
		prod_h = r_q * height_q;
		prod_s = r_q * 4'd14;
		prod_l = r_q * sp_q.life_total;
		prod_k = r_q * 11'd1434;
		tot_v = 19'd196608 + {1'b0, r_q[23:6]};
		ang_idx = r_q[23 -: AB];
		ang_j = ang_idx[AB-3:0];
		ang_swap = {1'b0, ang_j, 1'b0} > {1'b0, QUARTER};
		ang_jj = ang_swap ? (QUARTER - {1'b0, ang_j}) : {1'b0, ang_j};
		sc = sc_tab[ang_jj[AB-3:0]];
		s_v = $signed(sc[31:16]);
		c_v = $signed(sc[15:0]);
		sa = ang_swap ? c_v : s_v;
		ca = ang_swap ? s_v : c_v;
		case (ang_idx[AB-1:AB-2])
			2'd0: begin dx = ca; dy = sa; end
			2'd1: begin dx = -sa; dy = ca; end
			2'd2: begin dx = -ca; dy = -sa; end
			default: begin dx = sa; dy = -ca; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) dt_q <= tick_dt;
		if (cmd.draw) r_q <= rng_nxt[23:0];
		if (cmd.use_en) begin
			case (cmd.op)
				dmp_pkg::OP_X: sp_q.pos_x <= {2'b00, prod_w[35:16]};
				dmp_pkg::OP_Y: sp_q.pos_y <= {2'b00, prod_h[35:16]};
				dmp_pkg::OP_ANG: begin
					sp_q.dir_x <= dx;
					sp_q.dir_y <= dy;
				end
				dmp_pkg::OP_SPD: speed_q <= 13'd1536 + {1'b0, prod_s[27:16]};
				dmp_pkg::OP_TOT: begin
					sp_q.life_total <= tot_v;
					sp_q.life_left <= {1'b0, tot_v};
				end
				dmp_pkg::OP_LIFE: sp_q.life_left <= {1'b0, prod_l[42:24]};
				dmp_pkg::OP_HW: sp_q.hwid <= 10'd205 + {1'b0, prod_k[34:26]};
				dmp_pkg::OP_SHD: sp_q.shade <= 12'd1434 + {1'b0, prod_k[34:24]};
				default: ;
			endcase
		end
		if (cmd.vel) begin
			sp_q.vel_x <= 15'(dmp_pkg::shr_round($signed({1'b0, speed_q}) * sp_q.dir_x, 14));
			sp_q.vel_y <= 15'(dmp_pkg::shr_round($signed({1'b0, speed_q}) * sp_q.dir_y, 14));
		end
	end

	// mote store
	assign wdata = cmd.wr_spawn ? sp_q : upd_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) mem[wr_addr] <= wdata;
		if (cmd.mem_rd) rd_q <= mem[rd_addr];
	end

	// motion and cull
	logic signed [47:0] mv_x, mv_y;
	logic signed [23:0] nx, ny;
	logic signed [20:0] nl;
	logic [20:0] lim_x, lim_y;
	logic keep_v;
	dmp_pkg::mote_t upd_v;

	always_comb begin
		mv_x = dmp_pkg::shr_round(rd_q.vel_x * $signed({1'b0, dt_q}), 16);
		mv_y = dmp_pkg::shr_round(rd_q.vel_y * $signed({1'b0, dt_q}), 16);
		nx = 24'(rd_q.pos_x) + mv_x[23:0];
		ny = 24'(rd_q.pos_y) + mv_y[23:0];
		nl = 21'(rd_q.life_left) - $signed({5'd0, dt_q});
		lim_x = {width_q + 12'd0, 8'd0} + 21'd10240;
		lim_y = {height_q + 12'd0, 8'd0} + 21'd10240;
		keep_v = (nl > 21'sd0)
			&& (nx > -24'sd10240) && (nx < $signed({3'b000, lim_x}))
			&& (ny > -24'sd10240) && (ny < $signed({3'b000, lim_y}));
		upd_v = rd_q;
		upd_v.pos_x = nx[21:0];
		upd_v.pos_y = ny[21:0];
		upd_v.life_left = nl[19:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.up_move) upd_q <= upd_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) keep_q <= 1'b0;
		else if (cmd.up_move) keep_q <= keep_v;
	end

	// fade: clamp, then shade*num/den by restoring division
	logic [18:0] lc_v, lc_q;
	logic [21:0] five_l, fact;
	logic [20:0] four_t;
	logic [19:0] two_t, den_v;
	logic case_a, case_b;
	logic [33:0] num_v;
	logic pass_q;
	logic [19:0] rem_q, den_q;
	logic [11:0] numlo_q, quo_q;
	logic [3:0] cnt_q;
	logic [20:0] trial;

	always_comb begin
		if (rd_q.life_left < 20'sd0) lc_v = 19'd0;
		else if (rd_q.life_left[18:0] > rd_q.life_total) lc_v = rd_q.life_total;
		else lc_v = rd_q.life_left[18:0];
		five_l = 22'(lc_q) * 22'd5;
		four_t = {rd_q.life_total, 2'b00};
		two_t = {rd_q.life_total, 1'b0};
		case_a = five_l > {1'b0, four_t};
		case_b = five_l < {2'b00, two_t};
		fact = case_a ? 22'(rd_q.life_total - lc_q) * 22'd5 : five_l;
		num_v = rd_q.shade * fact;
		den_v = case_a ? {1'b0, rd_q.life_total} : two_t;
		trial = {rem_q, numlo_q[11]};
	end

	always_ff @(posedge clk) begin
		if (cmd.em_prep) lc_q <= lc_v;
		if (cmd.em_mul) begin
			pass_q <= (rd_q.life_total == 19'd0) || (!case_a && !case_b);
			rem_q <= num_v[31:12];
			numlo_q <= num_v[11:0];
			den_q <= den_v;
		end else if (cnt_q != 4'd0) begin
			numlo_q <= {numlo_q[10:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 20'(trial - {1'b0, den_q});
				quo_q <= {quo_q[10:0], 1'b1};
			end else begin
				rem_q <= trial[19:0];
				quo_q <= {quo_q[10:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 4'd0;
		else if (cmd.em_mul) cnt_q <= 4'(dmp_pkg::DIV_STEPS);
		else if (cnt_q != 4'd0) cnt_q <= cnt_q - 4'd1;
	end

	assign sts.keep = keep_q;
	assign sts.div_done = (cnt_q == 4'd0);

	// stroke word
	logic [11:0] gray_v;
	logic [23:0] blue_p;
	logic signed [47:0] ox, oy;

	always_comb begin
		gray_v = pass_q ? rd_q.shade : quo_q;
		blue_p = gray_v * 12'd3891;
		ox = dmp_pkg::shr_round(rd_q.dir_x * 18'sd3, 6);
		oy = dmp_pkg::shr_round(rd_q.dir_y * 18'sd3, 6);
	end

	always_ff @(posedge clk) begin
		if (cmd.em_out) begin
			start_x <= rd_q.pos_x - ox[21:0];
			start_y <= rd_q.pos_y - oy[21:0];
			end_x <= rd_q.pos_x + ox[21:0];
			end_y <= rd_q.pos_y + oy[21:0];
			stroke_half_width <= rd_q.hwid;
			gray_level <= gray_v;
			blue_level <= blue_p[23:12];
			last_stroke <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.em_out;
	end

endmodule

[design/dmp_ctrl.sv]
// Controller: sequences fill, motion/cull, respawn and stroke output passes.
module dmp_ctrl #(
	parameter int NUM_MOTES = dmp_pkg::NUM_MOTES_DEF,
	localparam int AW = (NUM_MOTES > 1) ? $clog2(NUM_MOTES) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic start,
	output logic busy,
	input  dmp_pkg::sts_t sts,
	output dmp_pkg::cmd_t cmd,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr
);
	localparam int CW = $clog2(NUM_MOTES + 1);
	localparam logic [CW-1:0] LAST = CW'(NUM_MOTES - 1);
	localparam logic [CW-1:0] FULL = CW'(NUM_MOTES);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SP_DRAW = 4'd1;
	localparam logic [3:0] ST_SP_USE = 4'd2;
	localparam logic [3:0] ST_SP_VEL = 4'd3;
	localparam logic [3:0] ST_SP_WRITE = 4'd4;
	localparam logic [3:0] ST_UP_READ = 4'd5;
	localparam logic [3:0] ST_UP_MOVE = 4'd6;
	localparam logic [3:0] ST_UP_CHECK = 4'd7;
	localparam logic [3:0] ST_EM_READ = 4'd8;
	localparam logic [3:0] ST_EM_PREP = 4'd9;
	localparam logic [3:0] ST_EM_MUL = 4'd10;
	localparam logic [3:0] ST_EM_DIV = 4'd11;
	localparam logic [3:0] ST_EM_OUT = 4'd12;

	logic [3:0] state_q;
	logic [CW-1:0] i_q, dst_q;
	logic [dmp_pkg::OP_W-1:0] op_q;
	logic init_q, filled_q;

	assign busy = (state_q != ST_IDLE);
	assign rd_addr = i_q[AW-1:0];
	assign wr_addr = dst_q[AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.draw = (state_q == ST_SP_DRAW);
		cmd.use_en = (state_q == ST_SP_USE);
		cmd.vel = (state_q == ST_SP_VEL);
		cmd.mem_rd = (state_q == ST_UP_READ) || (state_q == ST_EM_READ);
		cmd.wr_spawn = (state_q == ST_SP_WRITE);
		cmd.mem_wr = (state_q == ST_SP_WRITE) || ((state_q == ST_UP_CHECK) && sts.keep);
		cmd.up_move = (state_q == ST_UP_MOVE);
		cmd.em_prep = (state_q == ST_EM_PREP);
		cmd.em_mul = (state_q == ST_EM_MUL);
		cmd.em_out = (state_q == ST_EM_OUT);
		cmd.last = (i_q == LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			dst_q <= '0;
			op_q <= dmp_pkg::OP_X;
			init_q <= 1'b0;
			filled_q <= 1'b0;
		end else begin
			if (cfg_write && (cfg_index == dmp_pkg::CFG_SEED)) filled_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					i_q <= '0;
					dst_q <= '0;
					op_q <= dmp_pkg::OP_X;
					init_q <= !filled_q;
					state_q <= filled_q ? ST_UP_READ : ST_SP_DRAW;
				end
				ST_SP_DRAW: state_q <= ST_SP_USE;
				ST_SP_USE: begin
					case (op_q)
						dmp_pkg::OP_SPD: state_q <= ST_SP_VEL;
						dmp_pkg::OP_SHD: state_q <= ST_SP_WRITE;
						dmp_pkg::OP_TOT: begin
							op_q <= init_q ? dmp_pkg::OP_LIFE : dmp_pkg::OP_HW;
							state_q <= ST_SP_DRAW;
						end
						default: begin
							op_q <= op_q + 3'd1;
							state_q <= ST_SP_DRAW;
						end
					endcase
				end
				ST_SP_VEL: begin
					op_q <= dmp_pkg::OP_TOT;
					state_q <= ST_SP_DRAW;
				end
				ST_SP_WRITE: begin
					op_q <= dmp_pkg::OP_X;
					if (dst_q == LAST) begin
						i_q <= '0;
						if (init_q) begin
							init_q <= 1'b0;
							filled_q <= 1'b1;
							dst_q <= '0;
							state_q <= ST_UP_READ;
						end else begin
							state_q <= ST_EM_READ;
						end
					end else begin
						dst_q <= dst_q + 1'b1;
						state_q <= ST_SP_DRAW;
					end
				end
				ST_UP_READ: state_q <= ST_UP_MOVE;
				ST_UP_MOVE: state_q <= ST_UP_CHECK;
				ST_UP_CHECK: begin
					dst_q <= dst_q + CW'(sts.keep);
					if (i_q == LAST) begin
						i_q <= '0;
						op_q <= dmp_pkg::OP_X;
						state_q <= ((dst_q + CW'(sts.keep)) == FULL) ? ST_EM_READ : ST_SP_DRAW;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_UP_READ;
					end
				end
				ST_EM_READ: state_q <= ST_EM_PREP;
				ST_EM_PREP: state_q <= ST_EM_MUL;
				ST_EM_MUL: state_q <= ST_EM_DIV;
				ST_EM_DIV: if (sts.div_done) state_q <= ST_EM_OUT;
				ST_EM_OUT: begin
					if (i_q == LAST) begin
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_EM_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[bench/drifting_mote_pool_tb.sv]
// Self-checking testbench for drifting_mote_pool: predicts every stroke word of each tick.
`timescale 1ns / 100ps

module drifting_mote_pool_tb;

	localparam int MOTES = 24;

	typedef struct {
		logic signed [21:0] sx, sy, ex, ey;
		logic [9:0] hw;
		logic [11:0] gray, blue;
		logic last;
	} stroke_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index = dmp_pkg::CFG_WIDTH;
	logic [31:0] cfg_data = '0;
	logic start = 1'b0;
	logic [15:0] tick_dt = '0;
	logic busy, result_valid, last_stroke;
	logic signed [21:0] start_x, start_y, end_x, end_y;
	logic [9:0] stroke_half_width;
	logic [11:0] gray_level, blue_level;

	drifting_mote_pool uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] rng_state;
	logic [11:0] scr_w, scr_h;
	bit pool_full;
	longint mx[MOTES], my[MOTES], mvx[MOTES], mvy[MOTES], mdx[MOTES], mdy[MOTES];
	longint mlife[MOTES], mtot[MOTES], mhw[MOTES], mshade[MOTES];

	stroke_t stroke_q[$];
	int errors = 0;

	function automatic longint round_shift(longint v, int sh);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 << (sh - 1))) >>> sh;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint draw24();
		rng_state = rng_state ^ (rng_state << 13);
		rng_state = rng_state ^ (rng_state >> 17);
		rng_state = rng_state ^ (rng_state << 5);
		return longint'(rng_state[23:0]);
	endfunction

	function automatic void angle_dir(longint idx, output longint cx, output longint sy);
		longint unsigned a, a2, t, s, c, tmp, jj, j;
		longint unsigned quad;
		bit swap;
		quad = (idx >> 8) & 3;
		j = idx & 255;
		swap = 2 * j > 256;
		jj = swap ? 256 - j : j;
		a = (jj * dmp_pkg::HALF_PI_Q30) >> 8;
		a2 = (a * a) >> 30;
		t = dmp_pkg::ONE_Q30 - a2 / 72;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 42;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 20;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 6;
		s = (((a * t) >> 30) + (64'd1 << 15)) >> 16;
		t = dmp_pkg::ONE_Q30 - a2 / 90;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 56;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 30;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 12;
		t = dmp_pkg::ONE_Q30 - ((a2 * t) >> 30) / 2;
		c = (t + (64'd1 << 15)) >> 16;
		if (swap) begin
			tmp = s; s = c; c = tmp;
		end
		case (quad)
			0: begin cx = c; sy = s; end
			1: begin cx = -longint'(s); sy = c; end
			2: begin cx = -longint'(c); sy = -longint'(s); end
			default: begin cx = s; sy = -longint'(c); end
		endcase
	endfunction

	function automatic void spawn_mote(int k, bit initial_fill);
		longint r, dx, dy, speed;
		r = draw24(); mx[k] = (r * scr_w) >>> 16;
		r = draw24(); my[k] = (r * scr_h) >>> 16;
		r = draw24(); angle_dir(r >>> 14, dx, dy);
		mdx[k] = dx; mdy[k] = dy;
		r = draw24(); speed = 1536 + ((r * 14) >>> 16);
		mvx[k] = round_shift(speed * dx, 14);
		mvy[k] = round_shift(speed * dy, 14);
		r = draw24(); mtot[k] = 196608 + (r >>> 6);
		if (initial_fill) begin
			r = draw24(); mlife[k] = (r * mtot[k]) >>> 24;
		end else
			mlife[k] = mtot[k];
		r = draw24(); mhw[k] = 205 + ((r * 1434) >>> 26);
		r = draw24(); mshade[k] = 1434 + ((r * 1434) >>> 24);
	endfunction

	function automatic bit on_screen(longint p, longint size);
		return p > -40 * 256 && p < (size + 40) * 256;
	endfunction

	function automatic longint fade_shade(int k);
		longint life, total;
		life = mlife[k];
		total = mtot[k];
		if (total <= 0) return mshade[k];
		if (life < 0) life = 0;
		if (life > total) life = total;
		if (5 * life > 4 * total) return (mshade[k] * 5 * (total - life)) / total;
		if (5 * life < 2 * total) return (mshade[k] * 5 * life) / (2 * total);
		return mshade[k];
	endfunction

	function automatic void predict_tick(logic [15:0] dt);
		int keep;
		longint ox, oy, g;
		stroke_t s;
		keep = 0;
		if (!pool_full)
			for (int i = 0; i < MOTES; i++) spawn_mote(i, 1'b1);
		pool_full = 1'b1;
		for (int i = 0; i < MOTES; i++) begin
			mx[i] += round_shift(mvx[i] * dt, 16);
			my[i] += round_shift(mvy[i] * dt, 16);
			mlife[i] -= dt;
		end
		for (int i = 0; i < MOTES; i++)
			if (mlife[i] > 0 && on_screen(mx[i], scr_w) && on_screen(my[i], scr_h)) begin
				mx[keep] = mx[i]; my[keep] = my[i];
				mvx[keep] = mvx[i]; mvy[keep] = mvy[i];
				mdx[keep] = mdx[i]; mdy[keep] = mdy[i];
				mlife[keep] = mlife[i]; mtot[keep] = mtot[i];
				mhw[keep] = mhw[i]; mshade[keep] = mshade[i];
				keep++;
			end
		while (keep < MOTES) spawn_mote(keep++, 1'b0);
		for (int i = 0; i < MOTES; i++) begin
			ox = round_shift(3 * mdx[i], 6);
			oy = round_shift(3 * mdy[i], 6);
			g = fade_shade(i) & 12'hFFF;
			s.sx = 22'(mx[i] - ox);
			s.sy = 22'(my[i] - oy);
			s.ex = 22'(mx[i] + ox);
			s.ey = 22'(my[i] + oy);
			s.hw = 10'(mhw[i]);
			s.gray = 12'(g);
			s.blue = 12'((g * 3891) >>> 12);
			s.last = (i == MOTES - 1);
			stroke_q.insert(stroke_q.size(), s);
		end
	endfunction

	// stroke checker
	always @(posedge clk) begin
		stroke_t e;
		if (result_valid) begin
			if (stroke_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected stroke word at %0t", $realtime);
			end else begin
				e = stroke_q.pop_front();
				if (start_x !== e.sx || start_y !== e.sy || end_x !== e.ex ||
					end_y !== e.ey || stroke_half_width !== e.hw ||
					gray_level !== e.gray || blue_level !== e.blue ||
					last_stroke !== e.last) begin
					errors++;
					if (errors <= 10) begin
						$display("stroke mismatch at %0t: exp %0d %0d %0d %0d hw %0d g %0d b %0d l %0b",
							$realtime, e.sx, e.sy, e.ex, e.ey, e.hw, e.gray, e.blue, e.last);
						$display("    got %0d %0d %0d %0d hw %0d g %0d b %0d l %0b",
							start_x, start_y, end_x, end_y, stroke_half_width,
							gray_level, blue_level, last_stroke);
					end
				end
			end
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 5);
		return $urandom_range(20, 150);
	endfunction

	task automatic send_tick(logic [15:0] dt, int gap);
		start <= 1'b1;
		tick_dt <= dt;
		do @(posedge clk); while (busy);
		predict_tick(dt);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (stroke_q.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [dmp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			dmp_pkg::CFG_WIDTH: scr_w = val[11:0];
			dmp_pkg::CFG_HEIGHT: scr_h = val[11:0];
			dmp_pkg::CFG_SEED: begin
				rng_state = (val != 0) ? val : dmp_pkg::SEED_DEF;
				pool_full = 1'b0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_dt_extremes();
		logic [15:0] dts[8] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h5555, 16'hAAAA,
			16'd1092, 16'hFFFF};
		foreach (dts[i]) send_tick(dts[i], pick_gap());
		wait_idle();
	endtask

	task automatic test_screen_extremes();
		write_reg(dmp_pkg::CFG_WIDTH, 32'd4095);
		write_reg(dmp_pkg::CFG_HEIGHT, 32'd1);
		for (int i = 0; i < 4; i++) send_tick(16'($urandom), pick_gap());
		wait_idle();
		write_reg(dmp_pkg::CFG_WIDTH, 32'd1);
		write_reg(dmp_pkg::CFG_HEIGHT, 32'd4095);
		for (int i = 0; i < 4; i++) send_tick(16'($urandom), pick_gap());
		wait_idle();
		write_reg(dmp_pkg::CFG_WIDTH, 32'd0);
		write_reg(dmp_pkg::CFG_HEIGHT, 32'd0);
		for (int i = 0; i < 3; i++) send_tick(16'd2000, pick_gap());
		wait_idle();
	endtask

	task automatic test_seeds();
		write_reg(dmp_pkg::CFG_WIDTH, 32'd640);
		write_reg(dmp_pkg::CFG_HEIGHT, 32'd480);
		write_reg(dmp_pkg::CFG_SEED, 32'd0);
		send_tick(16'd1092, 0);
		send_tick(16'd1092, pick_gap());
		wait_idle();
		write_reg(dmp_pkg::CFG_SEED, 32'hFFFF_FFFF);
		send_tick(16'hFFFF, pick_gap());
		wait_idle();
	endtask

	task automatic test_random_ticks();
		int p;
		logic [15:0] dt;
		for (int ph = 0; ph < 8; ph++) begin
			p = $urandom_range(3);
			write_reg(dmp_pkg::CFG_WIDTH, p == 0 ? 32'd4095 : 32'($urandom_range(1, 4095)));
			write_reg(dmp_pkg::CFG_HEIGHT, p == 1 ? 32'd1 : 32'($urandom_range(1, 4095)));
			if (ph % 3 == 0) write_reg(dmp_pkg::CFG_SEED, $urandom);
			for (int i = 0; i < 47; i++) begin
				p = $urandom_range(99);
				if (p < 60) dt = 16'($urandom_range(500, 4000));
				else if (p < 90) dt = 16'($urandom);
				else dt = p < 95 ? 16'd0 : 16'hFFFF;
				if (ph == 4 && i < 20) dt = 16'd0;
				send_tick(dt, ph == 5 ? 0 : pick_gap());
			end
			wait_idle();
		end
	endtask

	initial begin
		scr_w = dmp_pkg::WIDTH_RST;
		scr_h = dmp_pkg::HEIGHT_RST;
		rng_state = dmp_pkg::SEED_DEF;
		pool_full = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_dt_extremes();
		test_screen_extremes();
		test_seeds();
		test_random_ticks();
		repeat (50) @(posedge clk);
		if (errors == 0 && stroke_q.size() == 0)
			$display("drifting_mote_pool_tb: PASS");
		else
			$display("drifting_mote_pool_tb: FAIL");
		$finish;
	end

	initial begin
		#40ms;
		$display("drifting_mote_pool_tb: FAIL");
		$finish;
	end

endmodule

[files.f]
design/dmp_pkg.sv
design/dmp_datapath.sv
design/dmp_ctrl.sv
design/drifting_mote_pool.sv
bench/drifting_mote_pool_tb.sv
